// ----- design/dtq_pkg.sv -----
// dtq_pkg: request and result types, action and status codes, and the
// controller/datapath command and status structs of the deadline timer queue
// no dependencies
`timescale 1ns / 1ps

package dtq_pkg;

    // action codes of a request
    localparam logic [1:0] ACT_SUBMIT = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;

    // status codes of a result
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // delay scaling, seconds to milliseconds
    localparam logic [9:0] MS_PER_SEC = 10'd1000;
    localparam int         PROD_W     = 26;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] task_handle;
        logic [15:0] delay_seconds;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] popped_handle;
        logic [4:0]  entry_count;
    } res_item_t;

    // controller to datapath
    typedef struct packed {
        logic       load_item;
        logic       tick;
        logic       sub_write;
        logic       scan_step;
        logic       shift_start;
        logic       shift_step;
        logic       pop_commit;
        logic       load_result;
        logic [1:0] code;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic scan_last;
        logic shift_last;
        logic best_last;
        logic due;
    } stat_t;

endpackage

// ----- design/dtq_datapath.sv -----
// dtq_datapath: task memory, millisecond clock, occupancy, minimum scan,
// compaction shift and result register; depends on dtq_pkg
`timescale 1ns / 1ps

module dtq_datapath #(
    parameter int CAPACITY  = 16,
    parameter int TIME_BITS = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dtq_pkg::req_item_t req_item,
    input  dtq_pkg::cmd_t     cmd,
    output dtq_pkg::stat_t    stat,
    output dtq_pkg::res_item_t res_item
);

    import dtq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = TIME_BITS + 16;

    logic [ENT_W-1:0]     mem [CAPACITY];

    logic [TIME_BITS-1:0] now_reg;
    logic [CNT_W-1:0]     occ_reg;
    logic                 cmp_valid_reg;
    logic                 wr_pending_reg;

    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [IDX_W-1:0]     wr_idx_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_BITS-1:0] best_dl_reg;
    logic [15:0]          best_handle_reg;
    logic [15:0]          handle_in_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ENT_W-1:0]     rd_data_reg;
    res_item_t            res_reg;

    logic [IDX_W:0]       idx_inc;
    logic [IDX_W-1:0]     rd_addr;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [ENT_W-1:0]     wdata;
    logic [TIME_BITS-1:0] deadline;
    logic [TIME_BITS-1:0] rd_dl;
    logic [15:0]          rd_handle;
    logic [CNT_W-1:0]     idx_ext;
    logic [CNT_W-1:0]     best_ext;
    logic [CNT_W+4:0]     occ_wide;

    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign rd_addr   = cmd.shift_step ? idx_inc[IDX_W-1:0] : idx_reg;
    assign deadline  = now_reg + {{(TIME_BITS-PROD_W){1'b0}}, prod_reg};
    assign we        = cmd.sub_write | wr_pending_reg;
    assign waddr     = wr_pending_reg ? wr_idx_reg : occ_reg[IDX_W-1:0];
    assign wdata     = wr_pending_reg ? rd_data_reg : {deadline, handle_in_reg};
    assign rd_dl     = rd_data_reg[ENT_W-1:16];
    assign rd_handle = rd_data_reg[15:0];
    assign idx_ext   = CNT_W'(idx_reg);
    assign best_ext  = CNT_W'(best_idx_reg);
    assign occ_wide  = {5'd0, occ_reg};

    always_comb
    begin
        stat.full       = (occ_reg == CNT_W'(CAPACITY));
        stat.empty      = (occ_reg == '0);
        stat.scan_last  = (idx_ext + CNT_W'(1) == occ_reg);
        stat.shift_last = (idx_ext + CNT_W'(2) == occ_reg);
        stat.best_last  = (best_ext + CNT_W'(1) == occ_reg);
        stat.due        = (best_dl_reg <= now_reg);
    end

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            occ_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            wr_pending_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg  <= cmd.scan_step;
            wr_pending_reg <= cmd.shift_step;
            if (cmd.tick)
            begin
                now_reg <= now_reg + 1'b1;
            end
            if (cmd.sub_write)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
            else if (cmd.pop_commit)
            begin
                occ_reg <= occ_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            idx_reg       <= '0;
            handle_in_reg <= req_item.task_handle;
            prod_reg      <= PROD_W'(req_item.delay_seconds) * PROD_W'(MS_PER_SEC);
        end
        else if (cmd.shift_start)
        begin
            idx_reg <= best_idx_reg;
        end
        else if (cmd.scan_step || cmd.shift_step)
        begin
            idx_reg <= idx_inc[IDX_W-1:0];
        end
        cmp_idx_reg <= idx_reg;
        wr_idx_reg  <= idx_reg;
        // first minimum wins, so equal deadlines keep submission order
        if (cmp_valid_reg && ((cmp_idx_reg == '0) || (rd_dl < best_dl_reg)))
        begin
            best_idx_reg    <= cmp_idx_reg;
            best_dl_reg     <= rd_dl;
            best_handle_reg <= rd_handle;
        end
        if (cmd.load_result)
        begin
            res_reg.status        <= cmd.code;
            res_reg.popped_handle <= (cmd.code == ST_POPPED) ? best_handle_reg : 16'd0;
            res_reg.entry_count   <= occ_wide[4:0];
        end
    end

    assign res_item = res_reg;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sub_write |-> !stat.full)
        else $error("submit write into full store");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_commit |-> !stat.empty)
        else $error("removal from empty store");
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sub_write && wr_pending_reg))
        else $error("submit write collides with shift write");
`endif

endmodule

// ----- design/dtq_controller.sv -----
// dtq_controller: request sequencing state machine and result valid
// depends on dtq_pkg
`timescale 1ns / 1ps

module dtq_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic [1:0]     req_action,
    output logic           req_stall,
    output logic           res_valid,
    input  logic           res_stall,
    input  dtq_pkg::stat_t stat,
    output dtq_pkg::cmd_t  cmd
);

    import dtq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_SUB_WR    = 8'b0000_0010,
        S_SCAN      = 8'b0000_0100,
        S_SCAN_END  = 8'b0000_1000,
        S_CHECK     = 8'b0001_0000,
        S_SHIFT     = 8'b0010_0000,
        S_SHIFT_END = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] code_reg, code_next;
    logic       res_valid_reg, res_valid_next;

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        res_valid_next = res_valid_reg && res_stall;
        cmd            = '0;
        cmd.code       = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DONE;
                    code_next     = ST_OK;
                    case (req_action)
                        ACT_SUBMIT:
                        begin
                            if (stat.full)
                            begin
                                code_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_SUB_WR;
                            end
                        end
                        ACT_TICK:
                        begin
                            cmd.tick = 1'b1;
                        end
                        ACT_POP:
                        begin
                            if (stat.empty)
                            begin
                                code_next = ST_NONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            code_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SUB_WR:
            begin
                cmd.sub_write = 1'b1;
                state_next    = S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_DONE;
                if (!stat.due)
                begin
                    code_next = ST_NONE;
                end
                else
                begin
                    code_next = ST_POPPED;
                    if (stat.best_last)
                    begin
                        cmd.pop_commit = 1'b1;
                    end
                    else
                    begin
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (stat.shift_last)
                begin
                    state_next = S_SHIFT_END;
                end
            end
            S_SHIFT_END:
            begin
                cmd.pop_commit = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.load_result = 1'b1;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            code_reg      <= ST_OK;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            res_valid_reg <= res_valid_next;
        end
    end

`ifndef SYNTH
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> res_valid_reg)
        else $error("result dropped while stalled");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!res_valid_reg || !res_stall))
        else $error("result register overwritten");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid) |=> (state_reg != S_IDLE))
        else $error("request accepted without result sequence");
`endif

endmodule

// ----- design/deadline_timer_queue.sv -----
// deadline_timer_queue: top level of the delayed-task queue
// depends on dtq_pkg, dtq_controller, dtq_datapath
`timescale 1ns / 1ps

// usage
//   request channel: req_valid / req_stall / req_item carry one request
//   (submit, tick, or pop); a request moves when req_valid is high and
//   req_stall is low. exactly one result per request on res_valid /
//   res_stall / res_item, in request order.
// sequence from acceptance to result valid
//   tick, full submit, empty pop, unused action: straight to the result step
//   submit: delay*1000 product registered at accept, then memory write
//   pop: minimum scan over all occupied slots through the single memory read
//   port, then, if the task is due and not in the last slot, a shift of the slots
//   behind it to close the gap it leaves, since tasks stay packed in submit order
// throughput: one request at a time; the block returns to idle in the
//   cycle after loading a result; a new request is taken once the
//   previous result sits in the output register, so a stalled result does
//   not hold the next request back, only the one after it
// reset: clears task count, millisecond clock and result valid; the
//   task memory is not cleared and needs no clearing pass
// a stalled result holds its value until taken

module deadline_timer_queue #(
    parameter int CAPACITY  = 16,
    parameter int TIME_BITS = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dtq_pkg::req_item_t req_item,
    output logic               res_valid,
    input  logic               res_stall,
    output dtq_pkg::res_item_t res_item
);

    import dtq_pkg::*;

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: decodes the request, walks scan and shift, owns res_valid
    dtq_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req_item.action),
        .req_stall  (req_stall),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath: task memory, clock, occupancy, minimum search, result reg
    dtq_datapath #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_item (req_item),
        .cmd      (cmd),
        .stat     (stat),
        .res_item (res_item)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench of deadline_timer_queue, request/result types from dtq_pkg
// directed and random submit, tick and pop requests with random idling on both channels,
// every result compared against a behavioral model of the timer queue

module tb_top;
    import dtq_pkg::*;

    localparam int         CAPACITY        = 16;
    localparam int         TIME_BITS       = 48;
    localparam int         MS_PER_SECOND   = 1000;
    localparam logic [1:0] ACT_UNUSED      = 2'd3;
    // the one second walk already takes about a thousand requests
    localparam int         RANDOM_REQUESTS = 60;
    // a pop through a full store ends well within this, so any stray result still shows
    localparam int         SETTLE_CYCLES   = 60;
    // the limit covers the worst case of about 1150 requests many times over
    localparam int         CYCLE_LIMIT     = 1000000;
    // tasks that are not yet due can never leave during the random part, so keep few of them
    localparam int         MAX_PENDING     = 3;

    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [15:0]          handle;
        logic [15:0]          seq;
    } timer_slot_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req_item;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_item;

    // model of the queue: slots kept in submit order, as the block keeps them
    timer_slot_t          slots[$];
    logic [TIME_BITS-1:0] model_now_ms;
    logic [15:0]          model_seq;
    res_item_t            awaited_results[$];
    res_item_t            head_result;

    int error_count;
    int requests_sent;
    int results_checked;
    int popped_count;
    int full_count;
    int none_count;
    int cycle_count;
    bit req_no_idle;
    bit res_no_idle;

    deadline_timer_queue #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one step of the queue model: updates its state and gives the result the request causes
    task automatic timer_queue_step(input req_item_t item, output res_item_t outcome);
        timer_slot_t fresh;
        int          best;
        outcome = '0;
        case (item.action)
            ACT_SUBMIT:
            begin
                if (slots.size() >= CAPACITY)
                begin
                    outcome.status = ST_FULL;
                    full_count++;
                end
                else
                begin
                    fresh.deadline = model_now_ms + TIME_BITS'(item.delay_seconds)
                                     * TIME_BITS'(MS_PER_SECOND);
                    fresh.handle   = item.task_handle;
                    fresh.seq      = model_seq;
                    model_seq      = model_seq + 16'd1;
                    slots.insert(slots.size(), fresh);
                    outcome.status = ST_OK;
                end
            end
            ACT_TICK:
            begin
                model_now_ms   = model_now_ms + 1'b1;
                outcome.status = ST_OK;
            end
            ACT_POP:
            begin
                outcome.status = ST_NONE;
                if (slots.size() != 0)
                begin
                    // strict less-than keeps the earliest submitted among equal deadlines
                    best = 0;
                    for (int k = 1; k < slots.size(); k++)
                    begin
                        if (slots[k].deadline < slots[best].deadline)
                            best = k;
                    end
                    if (slots[best].deadline <= model_now_ms)
                    begin
                        outcome.status        = ST_POPPED;
                        outcome.popped_handle = slots[best].handle;
                        slots.delete(best);
                    end
                end
                if (outcome.status == ST_POPPED)
                    popped_count++;
                else
                    none_count++;
            end
            default:
                outcome.status = ST_OK;
        endcase
        outcome.entry_count = 5'(slots.size());
    endtask

    // tasks in the model whose deadline lies ahead of the clock
    function automatic int pending_count();
        int n;
        n = 0;
        foreach (slots[k])
        begin
            if (slots[k].deadline > model_now_ms)
                n++;
        end
        return n;
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    // mostly due at once; now and then a task that waits, short or long
    function automatic logic [15:0] pick_delay();
        if (pending_count() < MAX_PENDING && $urandom_range(0, 7) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                return 16'($urandom_range(1, 2));
            return 16'($urandom_range(1, 65535));
        end
        return 16'd0;
    endfunction

    // send one request: optional idle gap, then hold it until the block takes it
    task automatic send_request(input logic [1:0] action, input logic [15:0] handle,
                                input logic [15:0] delay);
        req_item_t item;
        res_item_t outcome;
        int        gap;
        item.action        = action;
        item.task_handle   = handle;
        item.delay_seconds = delay;
        gap = req_no_idle ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= item;
        do
            @(posedge clk);
        while (req_stall);
        timer_queue_step(item, outcome);
        awaited_results.insert(awaited_results.size(), outcome);
        requests_sent++;
    endtask

    // result side: wait a random number of cycles per result, then take it
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            int hold;
            @(negedge clk);
            if ($urandom_range(0, 31) == 0)
                res_no_idle = !res_no_idle;
            hold = res_no_idle ? 0 : $urandom_range(0, 9);
            if (hold != 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!res_valid);
        end
    end

    // compare every taken result with the oldest awaited one
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no request waiting: status %0d handle %0h count %0d",
                       res_item.status, res_item.popped_handle, res_item.entry_count);
                error_count++;
            end
            else
            begin
                head_result = awaited_results.pop_front();
                results_checked++;
                if (res_item.status !== head_result.status)
                begin
                    $error("status: expected %0d, got %0d",
                           head_result.status, res_item.status);
                    error_count++;
                end
                if (res_item.popped_handle !== head_result.popped_handle)
                begin
                    $error("popped_handle: expected %0h, got %0h",
                           head_result.popped_handle, res_item.popped_handle);
                    error_count++;
                end
                if (res_item.entry_count !== head_result.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           head_result.entry_count, res_item.entry_count);
                    error_count++;
                end
            end
        end
    end

    // pop on an empty store, the unused action code and a plain tick
    task automatic idle_queue_test();
        send_request(ACT_POP, 16'h0000, 16'h0000);
        send_request(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
        send_request(ACT_TICK, 16'hFFFF, 16'h0000);
    endtask

    // largest handle and delay stay parked; an earlier deadline behind it must still leave first
    task automatic field_extremes_test();
        send_request(ACT_SUBMIT, 16'hFFFF, 16'hFFFF);
        send_request(ACT_SUBMIT, 16'h0000, 16'h0000);
        send_request(ACT_POP, 16'h0000, 16'hFFFF);
        send_request(ACT_POP, 16'hFFFF, 16'h0000);
    endtask

    // equal deadlines leave in submit order
    task automatic equal_deadline_test();
        send_request(ACT_SUBMIT, 16'h1111, 16'h0000);
        send_request(ACT_SUBMIT, 16'h2222, 16'h0000);
        send_request(ACT_SUBMIT, 16'h3333, 16'h0000);
        repeat (3) send_request(ACT_POP, 16'h0000, 16'h0000);
    endtask

    // fill every slot, then one submit too many and a pop from the full store
    task automatic full_queue_test();
        int room;
        room = CAPACITY - slots.size();
        repeat (room) send_request(ACT_SUBMIT, rand16(), 16'h0000);
        send_request(ACT_SUBMIT, 16'hABCD, 16'h0000);
        send_request(ACT_POP, 16'h0000, 16'h0000);
    endtask

    // bursts of submits, pops and ticks with random content, plus some unshaped noise
    task automatic random_traffic_test();
        int         stop_at;
        int         kind;
        int         burst;
        logic [1:0] act;
        stop_at = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < stop_at)
        begin
            kind        = $urandom_range(0, 9);
            burst       = $urandom_range(1, CAPACITY + 1);
            req_no_idle = ($urandom_range(0, 4) == 0);
            if (kind <= 2)
                repeat (burst) send_request(ACT_SUBMIT, rand16(), pick_delay());
            else if (kind <= 5)
                repeat (burst) send_request(ACT_POP, rand16(), rand16());
            else if (kind <= 7)
                repeat ($urandom_range(1, 20)) send_request(ACT_TICK, rand16(), rand16());
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    act = 2'($urandom_range(0, 3));
                    send_request(act, rand16(), (act == ACT_SUBMIT) ? pick_delay() : rand16());
                end
            end
        end
        req_no_idle = 1'b0;
    endtask

    // a one second delay must come due after exactly 1000 ticks, not one earlier
    task automatic second_boundary_test();
        repeat (CAPACITY + 1) send_request(ACT_POP, rand16(), rand16());
        send_request(ACT_SUBMIT, 16'h5A5A, 16'd1);
        repeat (MS_PER_SECOND - 1) send_request(ACT_TICK, rand16(), rand16());
        send_request(ACT_POP, 16'h0000, 16'h0000);
        send_request(ACT_TICK, 16'h0000, 16'h0000);
        repeat (MAX_PENDING + 1) send_request(ACT_POP, 16'h0000, 16'h0000);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_item     = '0;
        model_now_ms = '0;
        model_seq    = '0;
        error_count     = 0;
        requests_sent   = 0;
        results_checked = 0;
        popped_count    = 0;
        full_count      = 0;
        none_count      = 0;
        cycle_count     = 0;
        req_no_idle     = 1'b0;
        res_no_idle     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_queue_test();
        field_extremes_test();
        equal_deadline_test();
        full_queue_test();
        random_traffic_test();
        second_boundary_test();

        @(negedge clk);
        req_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d requests and %0d checked results, clock at %0d ms",
                 requests_sent, results_checked, model_now_ms);
        $display("tasks popped %0d, nothing due %0d, store full %0d",
                 popped_count, none_count, full_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
design/dtq_pkg.sv
design/dtq_datapath.sv
design/dtq_controller.sv
design/deadline_timer_queue.sv
tb/tb_top.sv
